[sv/assert_macros.svh]
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define USPH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define USPH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/usph_pkg.sv]
// Shared constants and types of the UV sphere tessellator.
`default_nettype none
package usph_pkg;

  localparam int unsigned MAX_STACKS  = 256;
  localparam int unsigned MAX_SECTORS = 256;

  // divider chain: 9 index bits plus 32 fraction bits
  localparam int CHAIN_LEN = 41;
  localparam int U_TAP     = 24;  // after j plus 16 fraction bits
  localparam int V_TAP     = 25;  // after leading zero, i, 16 fraction bits

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] K_C1    = 31'd1686629713;
  localparam logic [30:0] K_C3    = 31'd693598668;
  localparam logic [30:0] K_C5    = 31'd85569306;
  localparam logic [30:0] K_C7    = 31'd5026995;
  localparam logic [30:0] K_C9    = 31'd172272;

  localparam logic [2:0] REG_STACK_COUNT   = 3'd0;
  localparam logic [2:0] REG_SECTOR_COUNT  = 3'd1;
  localparam logic [2:0] REG_CENTER_X      = 3'd2;
  localparam logic [2:0] REG_CENTER_Y      = 3'd3;
  localparam logic [2:0] REG_CENTER_Z      = 3'd4;
  localparam logic [2:0] REG_SPHERE_RADIUS = 3'd5;

  typedef struct packed {
    logic        valid;
    logic        op;
    logic        bad;
    logic [16:0] a;
    logic [16:0] u;
    logic [16:0] v;
  } pl_t;

  typedef struct packed {
    pl_t         pl;
    logic [40:0] dt;
    logic [40:0] dp;
    logic [8:0]  rt;
    logic [8:0]  rp;
    logic [32:0] qt;
    logic [31:0] qp;
  } cell_t;

endpackage
`default_nettype wire

[sv/usph_div_cell.sv]
// One cell of the divider chain: a quotient bit for theta and for phi.
`default_nettype none
module usph_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [8:0]     stacks,
  input  logic [8:0]     sectors,
  input  logic           cap_u,
  input  logic           cap_v,
  input  usph_pkg::cell_t d_in,
  output usph_pkg::cell_t d_out
);
  import usph_pkg::*;

  cell_t       c_r;
  cell_t       c_nxt;
  logic [9:0]  rt_sh;
  logic [9:0]  rp_sh;
  logic        ge_t;
  logic        ge_p;
  logic [8:0]  rt_new;
  logic [8:0]  rp_new;
  logic [32:0] qt_new;
  logic [31:0] qp_new;
  logic        rnd_u;
  logic        rnd_v;

  always_comb begin
    rt_sh  = {d_in.rt, d_in.dt[40]};
    rp_sh  = {d_in.rp, d_in.dp[40]};
    ge_t   = rt_sh >= {1'b0, sectors};
    ge_p   = rp_sh >= {1'b0, stacks};
    rt_new = ge_t ? 9'(rt_sh - {1'b0, sectors}) : rt_sh[8:0];
    rp_new = ge_p ? 9'(rp_sh - {1'b0, stacks}) : rp_sh[8:0];
    qt_new = {d_in.qt[31:0], ge_t};
    qp_new = {d_in.qp[30:0], ge_p};
    // round half up: remainder + floor(d/2) reaches d
    rnd_u  = ({1'b0, rt_new} + {2'b0, sectors[8:1]}) >= {1'b0, sectors};
    rnd_v  = ({1'b0, rp_new} + {2'b0, stacks[8:1]}) >= {1'b0, stacks};

    c_nxt    = d_in;
    c_nxt.rt = rt_new;
    c_nxt.rp = rp_new;
    c_nxt.dt = {d_in.dt[39:0], 1'b0};
    c_nxt.dp = {d_in.dp[39:0], 1'b0};
    c_nxt.qt = qt_new;
    c_nxt.qp = qp_new;
    if (cap_u) begin
      c_nxt.pl.u = qt_new[16:0] + {16'd0, rnd_u};
    end
    if (cap_v) begin
      c_nxt.pl.v = qp_new[16:0] + {16'd0, rnd_v};
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    if (!rst_n) begin
      c_r.pl.valid <= 1'b0;
    end
  end

  assign d_out = c_r;

endmodule
`default_nettype wire

[sv/usph_qsine.sv]
// Pipelined fixed-point sine of a 32 bit phase, Q30 result.
`default_nettype none
module usph_qsine (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [31:0] sine
);
  import usph_pkg::*;

  logic [30:0] f_r   [0:5];
  logic        neg_r [0:5];
  logic [30:0] f2_r  [0:3];
  logic [30:0] t_r   [0:3];
  logic signed [31:0] sine_r;

  logic [30:0] f_in;
  logic [61:0] p_sq;
  logic [61:0] p_t0;
  logic [61:0] p_t1;
  logic [61:0] p_t2;
  logic [61:0] p_t3;
  logic [61:0] p_s;
  logic [31:0] t0_new;
  logic [31:0] t1_new;
  logic [31:0] t2_new;
  logic [31:0] t3_new;
  logic [31:0] s_raw;
  logic [30:0] s_cap;

  always_comb begin
    // odd quadrants mirror the fraction
    f_in   = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    p_sq   = {31'd0, f_r[0]} * {31'd0, f_r[0]};
    p_t0   = {31'd0, f2_r[0]} * {31'd0, K_C9};
    p_t1   = {31'd0, f2_r[1]} * {31'd0, t_r[0]};
    p_t2   = {31'd0, f2_r[2]} * {31'd0, t_r[1]};
    p_t3   = {31'd0, f2_r[3]} * {31'd0, t_r[2]};
    p_s    = {31'd0, f_r[5]} * {31'd0, t_r[3]};
    t0_new = {1'b0, K_C7} - p_t0[61:30];
    t1_new = {1'b0, K_C5} - p_t1[61:30];
    t2_new = {1'b0, K_C3} - p_t2[61:30];
    t3_new = {1'b0, K_C1} - p_t3[61:30];
    s_raw  = p_s[61:30];
    s_cap  = (s_raw > {1'b0, Q30_ONE}) ? Q30_ONE : s_raw[30:0];
  end

  always_ff @(posedge clk) begin
    f_r[0]   <= f_in;
    neg_r[0] <= phase[31];
    for (int k = 1; k < 6; k++) begin
      f_r[k]   <= f_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end
    f2_r[0] <= p_sq[60:30];
    for (int k = 1; k < 4; k++) begin
      f2_r[k] <= f2_r[k-1];
    end
    t_r[0] <= t0_new[30:0];
    t_r[1] <= t1_new[30:0];
    t_r[2] <= t2_new[30:0];
    t_r[3] <= t3_new[30:0];
    sine_r <= neg_r[5] ? signed'(32'd0 - {1'b0, s_cap}) : signed'({1'b0, s_cap});
  end

  assign sine = sine_r;

endmodule
`default_nettype wire

[sv/uv_sphere_tessellator_core.sv]
// Top level of the UV sphere tessellator: divider chain, sine units, output sequencer.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------------------
//  input   | in_op, in_stack_index, in_sector_index   | start high and busy low
//  result  | out_pos_*, out_normal_*, out_tex_*, ...  | out_valid, never stalled
//  config  | cfg_index, cfg_wdata                     | cfg_we, taken at once
//
//  From accept to the first result an item passes 41 divider cells, one
//  rounding stage, 7 sine stages, two product stages and the output register.
//  Vertex items and flagged items are taken one per cycle while busy is low.
//  A quad item inside the grid gives six results on consecutive cycles and
//  raises busy after it is taken.
//  Reset is synchronous, active low; it clears valid flags, the sequencer and
//  loads the register defaults. The receiver cannot stall the results.
`default_nettype none
module uv_sphere_tessellator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [8:0]         in_stack_index,
  input  logic [8:0]         in_sector_index,
  output logic               out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic [16:0]        out_vertex_index,
  output logic               out_last_result,
  output logic               out_bad_request,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import usph_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [8:0]         stack_count_r;
  logic [8:0]         sector_count_r;
  logic signed [31:0] center_x_r;
  logic signed [31:0] center_y_r;
  logic signed [31:0] center_z_r;
  logic [30:0]        radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_count_r  <= 9'd16;
      sector_count_r <= 9'd32;
      center_x_r     <= '0;
      center_y_r     <= '0;
      center_z_r     <= '0;
      radius_r       <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STACK_COUNT:   stack_count_r  <= cfg_wdata[8:0];
        REG_SECTOR_COUNT:  sector_count_r <= cfg_wdata[8:0];
        REG_CENTER_X:      center_x_r     <= signed'(cfg_wdata);
        REG_CENTER_Y:      center_y_r     <= signed'(cfg_wdata);
        REG_CENTER_Z:      center_z_r     <= signed'(cfg_wdata);
        REG_SPHERE_RADIUS: radius_r       <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Zero counts act as one, large counts clamp to the grid maximum.
  logic [8:0] ns_eff;
  logic [8:0] np_eff;

  always_comb begin
    if (stack_count_r == 9'd0) begin
      ns_eff = 9'd1;
    end else if (stack_count_r > 9'(MAX_STACKS)) begin
      ns_eff = 9'(MAX_STACKS);
    end else begin
      ns_eff = stack_count_r;
    end
    if (sector_count_r == 9'd0) begin
      np_eff = 9'd1;
    end else if (sector_count_r > 9'(MAX_SECTORS)) begin
      np_eff = 9'(MAX_SECTORS);
    end else begin
      np_eff = sector_count_r;
    end
  end

  // ---------------------------------------------------------------- accept
  logic       accept;
  logic       in_ok;
  logic [9:0] np_plus1;
  logic [18:0] row_base;
  logic [2:0] qcnt_r;
  logic [2:0] qcnt_nxt;

  assign busy   = (qcnt_r != 3'd0);
  assign accept = start & ~busy;

  always_comb begin
    if (in_op) begin
      in_ok = (in_stack_index < ns_eff) && (in_sector_index < np_eff);
    end else begin
      in_ok = (in_stack_index <= ns_eff) && (in_sector_index <= np_eff);
    end
    np_plus1 = {1'b0, np_eff} + 10'd1;
    row_base = 19'(in_stack_index) * 19'(np_plus1);
  end

  // a valid quad occupies six output slots: keep the input slots under its other results empty
  always_comb begin
    qcnt_nxt = qcnt_r;
    if (accept && in_op && in_ok) begin
      qcnt_nxt = 3'd5;
    end else if (qcnt_r != 3'd0) begin
      qcnt_nxt = qcnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
    end
  end

  // ---------------------------------------------------------------- divider chain
  // Long division of j*2^32 by sectors and i*2^31 by stacks, one bit per cell.
  cell_t chain [0:CHAIN_LEN];

  always_comb begin
    chain[0].pl.valid = accept;
    chain[0].pl.op    = in_op;
    chain[0].pl.bad   = ~in_ok;
    chain[0].pl.a     = 17'(row_base + 19'(in_sector_index));
    chain[0].pl.u     = '0;
    chain[0].pl.v     = '0;
    chain[0].dt       = {in_sector_index, 32'd0};
    chain[0].dp       = {1'b0, in_stack_index, 31'd0};
    chain[0].rt       = '0;
    chain[0].rp       = '0;
    chain[0].qt       = '0;
    chain[0].qp       = '0;
  end

  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
    usph_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stacks  (ns_eff),
      .sectors (np_eff),
      .cap_u   (k == U_TAP),
      .cap_v   (k == V_TAP),
      .d_in    (chain[k]),
      .d_out   (chain[k+1])
    );
  end

  // ---------------------------------------------------------------- phase rounding
  logic        rnd_t;
  logic        rnd_p;
  logic [32:0] th_sum;
  logic [31:0] ph_q;
  logic [31:0] th_r;
  logic [31:0] ph_r;
  pl_t         plr_r;

  always_comb begin
    rnd_t  = ({1'b0, chain[CHAIN_LEN].rt} + {2'b0, np_eff[8:1]}) >= {1'b0, np_eff};
    rnd_p  = ({1'b0, chain[CHAIN_LEN].rp} + {2'b0, ns_eff[8:1]}) >= {1'b0, ns_eff};
    th_sum = chain[CHAIN_LEN].qt + {32'd0, rnd_t};
    ph_q   = chain[CHAIN_LEN].qp + {31'd0, rnd_p};
  end

  always_ff @(posedge clk) begin
    th_r  <= th_sum[31:0];
    ph_r  <= 32'hC000_0000 - ph_q;   // -quarter turn minus the stack angle
    plr_r <= chain[CHAIN_LEN].pl;
    if (!rst_n) begin
      plr_r.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- sine units
  logic signed [31:0] xy_s;
  logic signed [31:0] z_s;
  logic signed [31:0] ct_s;
  logic signed [31:0] st_s;

  usph_qsine u_cos_ph (.clk(clk), .phase(ph_r + 32'h4000_0000), .sine(xy_s));
  usph_qsine u_sin_ph (.clk(clk), .phase(ph_r),                 .sine(z_s));
  usph_qsine u_cos_th (.clk(clk), .phase(th_r + 32'h4000_0000), .sine(ct_s));
  usph_qsine u_sin_th (.clk(clk), .phase(th_r),                 .sine(st_s));

  pl_t pd_r [0:6];

  always_ff @(posedge clk) begin
    pd_r[0] <= plr_r;
    for (int k = 1; k < 7; k++) begin
      pd_r[k] <= pd_r[k-1];
    end
    if (!rst_n) begin
      for (int k = 0; k < 7; k++) begin
        pd_r[k].valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- products
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] p;
    logic [31:0] m;
    ma = 31'(a[31] ? -a : a);
    mb = 31'(b[31] ? -b : b);
    p  = {31'd0, ma} * {31'd0, mb} + 62'h2000_0000;
    m  = p[61:30];
    return (a[31] ^ b[31]) ? signed'(32'd0 - m) : signed'(m);
  endfunction

  function automatic logic [31:0] pos_mag(input logic signed [31:0] c,
                                          input logic [30:0] r);
    logic [30:0] mc;
    logic [61:0] p;
    mc = 31'(c[31] ? -c : c);
    p  = {31'd0, mc} * {31'd0, r} + 62'h2000_0000;
    return p[61:30];
  endfunction

  function automatic logic [15:0] to_normal(input logic signed [31:0] c);
    logic [30:0] mc;
    logic [30:0] s;
    logic [15:0] n;
    mc = 31'(c[31] ? -c : c);
    s  = mc + 31'h8000;
    n  = {1'b0, s[30:16]};
    return c[31] ? 16'(16'd0 - n) : n;
  endfunction

  logic signed [31:0] x1_r;
  logic signed [31:0] y1_r;
  logic signed [31:0] z1_r;
  pl_t                pl1_r;

  always_ff @(posedge clk) begin
    x1_r  <= mul_q30(xy_s, ct_s);
    y1_r  <= mul_q30(xy_s, st_s);
    z1_r  <= z_s;
    pl1_r <= pd_r[6];
    if (!rst_n) begin
      pl1_r.valid <= 1'b0;
    end
  end

  logic [31:0] mx_r;
  logic [31:0] my_r;
  logic [31:0] mz_r;
  logic        sx_r;
  logic        sy_r;
  logic        sz_r;
  logic [15:0] nx_r;
  logic [15:0] ny_r;
  logic [15:0] nz_r;
  pl_t         pl2_r;

  // position axes: x from x, y from sin phi, z from the theta sine term
  always_ff @(posedge clk) begin
    mx_r  <= pos_mag(x1_r, radius_r);
    my_r  <= pos_mag(z1_r, radius_r);
    mz_r  <= pos_mag(y1_r, radius_r);
    sx_r  <= x1_r[31];
    sy_r  <= z1_r[31];
    sz_r  <= y1_r[31];
    nx_r  <= to_normal(x1_r);
    ny_r  <= to_normal(z1_r);
    nz_r  <= to_normal(y1_r);
    pl2_r <= pl1_r;
    if (!rst_n) begin
      pl2_r.valid <= 1'b0;
    end
  end

  function automatic logic [31:0] sat_pos(input logic signed [31:0] ctr,
                                          input logic [31:0] mag,
                                          input logic neg);
    logic [33:0] s;
    s = {{2{ctr[31]}}, ctr} + (neg ? 34'(34'd0 - {2'b0, mag}) : {2'b0, mag});
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
      return s[31:0];
    end else if (s[33]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  // ---------------------------------------------------------------- output sequencer
  logic [2:0]  step_r;
  logic [2:0]  step_nxt;
  logic [16:0] qa_r;
  logic [16:0] qa_nxt;
  logic [16:0] qb_r;
  logic [16:0] qb_nxt;

  logic        valid_r,  valid_nxt;
  logic [31:0] px_r,     px_nxt;
  logic [31:0] py_r,     py_nxt;
  logic [31:0] pz_r,     pz_nxt;
  logic [15:0] onx_r,    onx_nxt;
  logic [15:0] ony_r,    ony_nxt;
  logic [15:0] onz_r,    onz_nxt;
  logic [16:0] tu_r,     tu_nxt;
  logic [16:0] tv_r,     tv_nxt;
  logic [16:0] vi_r,     vi_nxt;
  logic        last_r,   last_nxt;
  logic        bad_r,    bad_nxt;

  always_comb begin
    step_nxt  = step_r;
    qa_nxt    = qa_r;
    qb_nxt    = qb_r;
    valid_nxt = 1'b0;
    px_nxt    = '0;
    py_nxt    = '0;
    pz_nxt    = '0;
    onx_nxt   = '0;
    ony_nxt   = '0;
    onz_nxt   = '0;
    tu_nxt    = '0;
    tv_nxt    = '0;
    vi_nxt    = '0;
    last_nxt  = 1'b0;
    bad_nxt   = 1'b0;
    if (pl2_r.valid) begin
      valid_nxt = 1'b1;
      if (pl2_r.bad) begin
        last_nxt = 1'b1;
        bad_nxt  = 1'b1;
      end else if (!pl2_r.op) begin
        px_nxt   = sat_pos(center_x_r, mx_r, sx_r);
        py_nxt   = sat_pos(center_y_r, my_r, sy_r);
        pz_nxt   = sat_pos(center_z_r, mz_r, sz_r);
        onx_nxt  = nx_r;
        ony_nxt  = ny_r;
        onz_nxt  = nz_r;
        tu_nxt   = pl2_r.u;
        tv_nxt   = pl2_r.v;
        last_nxt = 1'b1;
      end else begin
        // first corner now, the other five from the held indices
        vi_nxt   = pl2_r.a;
        qa_nxt   = pl2_r.a;
        qb_nxt   = pl2_r.a + {8'd0, np_eff} + 17'd1;
        step_nxt = 3'd1;
      end
    end else if (step_r != 3'd0) begin
      valid_nxt = 1'b1;
      case (step_r)
        3'd1: vi_nxt = qb_r;
        3'd2: vi_nxt = qb_r + 17'd1;
        3'd3: vi_nxt = qa_r;
        3'd4: vi_nxt = qb_r + 17'd1;
        3'd5: begin
          vi_nxt   = qa_r + 17'd1;
          last_nxt = 1'b1;
        end
        default: ;
      endcase
      step_nxt = (step_r == 3'd5) ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    qa_r  <= qa_nxt;
    qb_r  <= qb_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pz_r  <= pz_nxt;
    onx_r <= onx_nxt;
    ony_r <= ony_nxt;
    onz_r <= onz_nxt;
    tu_r  <= tu_nxt;
    tv_r  <= tv_nxt;
    vi_r  <= vi_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_pos_x        = signed'(px_r);
  assign out_pos_y        = signed'(py_r);
  assign out_pos_z        = signed'(pz_r);
  assign out_normal_x     = signed'(onx_r);
  assign out_normal_y     = signed'(ony_r);
  assign out_normal_z     = signed'(onz_r);
  assign out_tex_u        = tu_r;
  assign out_tex_v        = tv_r;
  assign out_vertex_index = vi_r;
  assign out_last_result  = last_r;
  assign out_bad_request  = bad_r;

endmodule
`default_nettype wire

[sv/usph_checker.sv]
// Port-level checker for the UV sphere tessellator and its bind.
`default_nettype none
`include "assert_macros.svh"
module usph_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_op,
  input logic out_valid,
  input logic out_last_result,
  input logic out_bad_request
);

  `USPH_ASSERT(a_bad_is_last, clk, rst_n, out_valid && out_bad_request |-> out_last_result, "flagged item not last")
  `USPH_ASSERT(a_quad_runs_on, clk, rst_n, out_valid && !out_last_result |=> out_valid, "gap inside quad results")
  `USPH_ASSERT(a_busy_from_quad, clk, rst_n, $rose(busy) |-> $past(start) && $past(in_op), "busy without quad item")
  `USPH_ASSERT(a_busy_holds, clk, rst_n, $rose(busy) |-> ##4 busy, "busy window too short")
  `USPH_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && !busy, "not idle after reset")

endmodule

bind uv_sphere_tessellator_core usph_checker u_usph_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_last_result (out_last_result),
  .out_bad_request (out_bad_request)
);
`default_nettype wire
